// ===== rtl/bsc_pkg.sv =====
// Shared types for the barometric compensation block.
// Holds the request/response structs between the sequencer and the divider.
// No dependencies.
`default_nettype none

package bsc_pkg;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic              start;
        logic              is_signed;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/bsc_div.sv =====
// Serial 32-bit restoring divider, one quotient bit per cycle.
// Signed mode truncates toward zero. Uses bsc_pkg request/response structs.
`default_nettype none

module bsc_div
    import bsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic              a_neg;
    logic              b_neg;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic              bit_ok;

    always_comb begin
        a_neg   = i_req.is_signed & i_req.dividend[DATA_W-1];
        b_neg   = i_req.is_signed & i_req.divisor[DATA_W-1];
        a_mag   = a_neg ? (~i_req.dividend + 1'b1) : i_req.dividend;
        b_mag   = b_neg ? (~i_req.divisor + 1'b1) : i_req.divisor;
        shifted = {r_rem, r_quo[DATA_W-1]};
        trial   = shifted - {1'b0, r_den};
        bit_ok  = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DATA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= a_mag;
            r_den <= b_mag;
            r_neg <= a_neg ^ b_neg;
        end else if (r_busy) begin
            r_rem <= bit_ok ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], bit_ok};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

// ===== rtl/baro_sensor_compensation.sv =====
// Barometric sensor compensation, top level: APB register file, sequencer,
// shared multiplier and output register. Depends on bsc_pkg and bsc_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries i_req_type and
//   i_raw_reading. Type 0 is a raw temperature reading (bits 23:8 used),
//   type 1 a raw pressure reading. Each transaction yields one result on the
//   output channel (o_out_valid / i_out_stall): o_result_kind, o_value and
//   o_div_fault (set with value 0 when a divisor was zero).
//   Calibration words and the oversampling setting are written over APB at
//   byte addresses 0, 8, 16 and 24; write them only while the block is idle,
//   the block itself does not enforce it. One item at a time: o_in_stall is
//   high from acceptance until the result is loaded into the output register.
//   Each item takes at most one divide in the serial divider and steps through
//   the formula on one shared 32x32 multiplier; a divide-by-zero item finishes early.
//   A finished result waits in the output register while the receiver
//   stalls; the next item is accepted meanwhile, and its result is held back
//   until the register frees up.
//   Reset clears the calibration words and stored B5, sets oversampling to
//   3 and empties the output register.
`default_nettype none

module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [23:0] i_raw_reading,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_result_kind,
    output logic signed [31:0] o_value,
    output logic             o_div_fault,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;
    localparam logic [1:0] REG_OSS    = 2'd3;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] T_MUL    = 5'd1;
    localparam logic [4:0] T_X1     = 5'd2;
    localparam logic [4:0] T_DEN    = 5'd3;
    localparam logic [4:0] T_DIV    = 5'd4;
    localparam logic [4:0] T_B5     = 5'd5;
    localparam logic [4:0] P_B6     = 5'd6;
    localparam logic [4:0] P_SQM    = 5'd7;
    localparam logic [4:0] P_SQ     = 5'd8;
    localparam logic [4:0] P_X1M    = 5'd9;
    localparam logic [4:0] P_X1     = 5'd10;
    localparam logic [4:0] P_X3     = 5'd11;
    localparam logic [4:0] P_B3     = 5'd12;
    localparam logic [4:0] P_X1B    = 5'd13;
    localparam logic [4:0] P_X2B    = 5'd14;
    localparam logic [4:0] P_X3B    = 5'd15;
    localparam logic [4:0] P_B4M    = 5'd16;
    localparam logic [4:0] P_B4     = 5'd17;
    localparam logic [4:0] P_B7     = 5'd18;
    localparam logic [4:0] P_DIV    = 5'd19;
    localparam logic [4:0] P_PX     = 5'd20;
    localparam logic [4:0] P_X2C    = 5'd21;
    localparam logic [4:0] P_M3038  = 5'd22;
    localparam logic [4:0] P_X1C    = 5'd23;
    localparam logic [4:0] P_X3C    = 5'd24;
    localparam logic [4:0] P_FIN    = 5'd25;
    localparam logic [4:0] ST_DONE  = 5'd26;

    localparam logic signed [31:0] K_T_ROUND  = 32'sd8;
    localparam logic signed [31:0] K_B6_OFF   = 32'sd4000;
    localparam logic signed [31:0] K_B3_ROUND = 32'sd2;
    localparam logic signed [31:0] K_X3_ROUND = 32'sd2;
    localparam logic signed [31:0] K_B4_OFF   = 32'sd32768;
    localparam logic [31:0]        K_P_SCALE  = 32'd50000;
    localparam logic signed [31:0] K_C1       = 32'sd3038;
    localparam logic signed [31:0] K_C2       = -32'sd7357;
    localparam logic signed [31:0] K_C3       = 32'sd3791;

    // signed divide by 2**k, truncating toward zero
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                   input logic [4:0] k);
        logic signed [31:0] bias;
        bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (a + bias) >>> k;
    endfunction

    // config registers
    logic [63:0] r_coef_a;
    logic [63:0] r_coef_b;
    logic [31:0] r_coef_c;
    logic [1:0]  r_oss;
    logic        cfg_wr;

    // sequencer and datapath
    logic [4:0]         r_state;
    logic               r_kind;
    logic [23:0]        r_raw;
    logic [63:0]        r_prod;
    logic signed [31:0] r_x1;
    logic signed [31:0] r_x2;
    logic signed [31:0] r_x3;
    logic signed [31:0] r_b6;
    logic signed [31:0] r_sq;
    logic signed [31:0] r_b3;
    logic [31:0]        r_b4;
    logic [31:0]        r_ps;
    logic               r_dbl;
    logic signed [31:0] r_tb5;
    logic signed [31:0] r_res;
    logic               r_fault;

    // output register
    logic               r_out_valid;
    logic               r_out_kind;
    logic signed [31:0] r_out_value;
    logic               r_out_fault;

    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic signed [31:0] ut_m_ac6;
    logic signed [31:0] den;
    logic [31:0]        up;
    logic [31:0]        b7;
    logic [31:0]        b4_now;
    logic signed [31:0] b3_sum;
    logic [31:0]        b3_sh;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic               out_free;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign ac1 = 32'(signed'(r_coef_a[63:48]));
    assign ac2 = 32'(signed'(r_coef_a[47:32]));
    assign ac3 = 32'(signed'(r_coef_a[31:16]));
    assign ac4 = 32'(r_coef_a[15:0]);
    assign ac5 = 32'(r_coef_b[63:48]);
    assign ac6 = 32'(r_coef_b[47:32]);
    assign b1  = 32'(signed'(r_coef_b[31:16]));
    assign b2  = 32'(signed'(r_coef_b[15:0]));
    assign mc  = 32'(signed'(r_coef_c[31:16]));
    assign md  = 32'(signed'(r_coef_c[15:0]));

    assign ut_m_ac6 = 32'(r_raw[23:8]) - ac6;
    assign den      = r_x1 + md;
    assign up       = 32'(r_raw >> (4'd8 - {2'b00, r_oss}));
    assign b7       = r_prod[31:0];
    // B4 product is taken at 32 bits before the shift
    assign b4_now   = {15'd0, r_prod[31:15]};
    assign b3_sum   = (ac1 <<< 2) + r_x3;
    assign b3_sh    = 32'(b3_sum) << r_oss;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[4:3])
            REG_COEF_A: prdata = r_coef_a;
            REG_COEF_B: prdata = r_coef_b;
            REG_COEF_C: prdata = {32'd0, r_coef_c};
            REG_OSS:    prdata = {62'd0, r_oss};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_oss    <= 2'd3;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_COEF_A: r_coef_a <= pwdata;
                REG_COEF_B: r_coef_b <= pwdata;
                REG_COEF_C: r_coef_c <= pwdata[31:0];
                REG_OSS:    r_oss    <= pwdata[1:0];
                default:    r_oss    <= r_oss;
            endcase
        end
    end

    // shared multiplier operand select; product registered every cycle
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            T_MUL: begin
                mul_a = ut_m_ac6;
                mul_b = ac5;
            end
            P_SQM: begin
                mul_a = r_b6;
                mul_b = r_b6;
            end
            P_X1M: begin
                mul_a = b2;
                mul_b = r_sq;
            end
            P_X1: begin
                mul_a = ac2;
                mul_b = r_b6;
            end
            P_B3: begin
                mul_a = ac3;
                mul_b = r_b6;
            end
            P_X1B: begin
                mul_a = b1;
                mul_b = r_sq;
            end
            P_B4M: begin
                mul_a = ac4;
                mul_b = r_x3 + K_B4_OFF;
            end
            P_B4: begin
                mul_a = up - r_b3;
                mul_b = K_P_SCALE >> r_oss;
            end
            P_PX: begin
                mul_a = K_C2;
                mul_b = r_ps;
            end
            P_X2C: begin
                mul_a = r_x1;
                mul_b = r_x1;
            end
            P_M3038: begin
                mul_a = r_prod[31:0];
                mul_b = K_C1;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // divider request
    always_comb begin
        div_req.start     = 1'b0;
        div_req.is_signed = 1'b0;
        div_req.dividend  = '0;
        div_req.divisor   = '0;
        case (r_state)
            T_DEN: begin
                div_req.start     = (den != 32'sd0);
                div_req.is_signed = 1'b1;
                div_req.dividend  = mc <<< 11;
                div_req.divisor   = den;
            end
            P_B7: begin
                div_req.start     = 1'b1;
                div_req.is_signed = 1'b0;
                div_req.dividend  = b7[31] ? b7 : (b7 << 1);
                div_req.divisor   = r_b4;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tb5   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= i_req_type;
                        r_raw   <= i_raw_reading;
                        r_fault <= 1'b0;
                        r_state <= i_req_type ? P_B6 : T_MUL;
                    end
                end
                T_MUL: r_state <= T_X1;
                T_X1: begin
                    r_x1    <= sdiv_p2(r_prod[31:0], 5'd15);
                    r_state <= T_DEN;
                end
                T_DEN: begin
                    if (den == 32'sd0) begin
                        r_fault <= 1'b1;
                        r_res   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= T_DIV;
                    end
                end
                T_DIV: begin
                    if (div_rsp.done) begin
                        r_x3    <= r_x1 + div_rsp.quotient;
                        r_state <= T_B5;
                    end
                end
                T_B5: begin
                    r_tb5   <= r_x3;
                    r_res   <= sdiv_p2(r_x3 + K_T_ROUND, 5'd4);
                    r_state <= ST_DONE;
                end
                P_B6: begin
                    r_b6    <= r_tb5 - K_B6_OFF;
                    r_state <= P_SQM;
                end
                P_SQM: r_state <= P_SQ;
                P_SQ: begin
                    r_sq    <= sdiv_p2(r_prod[31:0], 5'd12);
                    r_state <= P_X1M;
                end
                P_X1M: r_state <= P_X1;
                P_X1: begin
                    r_x1    <= sdiv_p2(r_prod[31:0], 5'd11);
                    r_state <= P_X3;
                end
                P_X3: begin
                    r_x3    <= r_x1 + sdiv_p2(r_prod[31:0], 5'd11);
                    r_state <= P_B3;
                end
                P_B3: begin
                    r_b3    <= sdiv_p2(b3_sh + K_B3_ROUND, 5'd2);
                    r_state <= P_X1B;
                end
                P_X1B: begin
                    r_x1    <= sdiv_p2(r_prod[31:0], 5'd13);
                    r_state <= P_X2B;
                end
                P_X2B: begin
                    r_x2    <= sdiv_p2(r_prod[31:0], 5'd16);
                    r_state <= P_X3B;
                end
                P_X3B: begin
                    r_x3    <= sdiv_p2(r_x1 + r_x2 + K_X3_ROUND, 5'd2);
                    r_state <= P_B4M;
                end
                P_B4M: r_state <= P_B4;
                P_B4: begin
                    r_b4 <= b4_now;
                    if (b4_now == 32'd0) begin
                        r_fault <= 1'b1;
                        r_res   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= P_B7;
                    end
                end
                P_B7: begin
                    // large B7 divides first, then doubles, as published
                    r_dbl   <= b7[31];
                    r_state <= P_DIV;
                end
                P_DIV: begin
                    if (div_rsp.done) begin
                        r_ps    <= r_dbl ? (div_rsp.quotient << 1) : div_rsp.quotient;
                        r_state <= P_PX;
                    end
                end
                P_PX: begin
                    r_x1    <= sdiv_p2(r_ps, 5'd8);
                    r_state <= P_X2C;
                end
                P_X2C: begin
                    r_x2    <= sdiv_p2(r_prod[31:0], 5'd16);
                    r_state <= P_M3038;
                end
                P_M3038: r_state <= P_X1C;
                P_X1C: begin
                    r_x1    <= sdiv_p2(r_prod[31:0], 5'd16);
                    r_state <= P_X3C;
                end
                P_X3C: begin
                    r_x3    <= sdiv_p2(r_x1 + r_x2 + K_C3, 5'd4);
                    r_state <= P_FIN;
                end
                P_FIN: begin
                    r_res   <= r_ps + r_x3;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_kind  <= r_kind;
            r_out_value <= r_res;
            r_out_fault <= r_fault;
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_value       = r_out_value;
    assign o_div_fault   = r_out_fault;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for baro_sensor_compensation: calibration registers over APB, raw
// temperature/pressure transactions in, compensated values checked against a
// local integer predictor. Needs only the RTL (bsc_pkg, bsc_div, top level).
`default_nettype none

module tb;

    typedef enum bit {
        KIND_TEMP = 1'b0,
        KIND_PRES = 1'b1
    } t_kind;

    typedef enum int {
        REG_COEF_A = 0,
        REG_COEF_B = 1,
        REG_COEF_C = 2,
        REG_OSS    = 3
    } t_reg;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        fault;
    } t_comp_result;

    // typical calibration set from the sensor's application note
    localparam logic [63:0] CAL_A = 64'h0198_FFB8_C7D1_7FE5;
    localparam logic [63:0] CAL_B = 64'h7FF5_5A71_182E_0004;
    localparam logic [31:0] CAL_C = 32'hDDF9_0B34;
    localparam int ITEMS_PER_SETTING = 97;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [23:0] i_raw_reading = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_result_kind;
    logic signed [31:0] o_value;
    logic        o_div_fault;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    baro_sensor_compensation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_raw_reading (i_raw_reading),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_value       (o_value),
        .o_div_fault   (o_div_fault),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic [63:0] cal_a = '0;
    logic [63:0] cal_b = '0;
    logic [31:0] cal_c = '0;
    logic [1:0]  cal_oss = 2'd3;
    int          held_b5 = 0;

    t_comp_result compensated_q[$];
    int error_count = 0;
    int temp_seen = 0;
    int pres_seen = 0;
    int fault_seen = 0;
    int write_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    initial forever #4 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, compensated_q.size());
        $display("FAILURE");
        $finish;
    end

    // C-style truncating division on 32-bit wrapped operands
    function automatic int sdiv(input int a, input int b);
        return int'(longint'(a) / longint'(b));
    endfunction

    function automatic t_comp_result compensate(input t_kind kind, input logic [23:0] raw);
        t_comp_result res;
        int ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        int ut, x1, x2, x3, den, b6, sq, b3, ps;
        bit [31:0] up, sh, b4, b7, p, diff, t;
        bit [63:0] prod;
        ac1 = $signed(cal_a[63:48]);
        ac2 = $signed(cal_a[47:32]);
        ac3 = $signed(cal_a[31:16]);
        ac4 = cal_a[15:0];
        ac5 = cal_b[63:48];
        ac6 = cal_b[47:32];
        b1  = $signed(cal_b[31:16]);
        b2  = $signed(cal_b[15:0]);
        mc  = $signed(cal_c[31:16]);
        md  = $signed(cal_c[15:0]);
        res.kind = kind;
        res.value = '0;
        res.fault = 1'b0;
        if (kind == KIND_TEMP) begin
            ut = raw[23:8];
            x1 = sdiv((ut - ac6) * ac5, 32768);
            den = x1 + md;
            if (den == 0) begin
                res.fault = 1'b1;   // stored B5 left alone
            end else begin
                x2 = sdiv(mc * 2048, den);
                held_b5 = x1 + x2;
                res.value = sdiv(held_b5 + 8, 16);
            end
        end else begin
            up = raw >> (8 - cal_oss);
            b6 = held_b5 - 4000;
            sq = sdiv(b6 * b6, 4096);
            x1 = sdiv(b2 * sq, 2048);
            x2 = sdiv(ac2 * b6, 2048);
            x3 = x1 + x2;
            sh = 32'(ac1 * 4 + x3);
            sh = sh << cal_oss;
            b3 = sdiv(int'(sh) + 2, 4);
            x1 = sdiv(ac3 * b6, 8192);
            x2 = sdiv(b1 * sq, 65536);
            x3 = sdiv(x1 + x2 + 2, 4);
            t = x3 + 32768;
            prod = {32'b0, 32'(ac4)} * {32'b0, t};
            // truncated to 32 bits before the shift
            b4 = prod[31:0] >> 15;
            if (b4 == 0) begin
                res.fault = 1'b1;
            end else begin
                diff = up - b3;
                prod = {32'b0, diff} * {32'b0, 32'(50000 >> cal_oss)};
                b7 = prod[31:0];
                if (b7 < 32'h8000_0000)
                    p = (b7 * 2) / b4;
                else
                    p = (b7 / b4) * 2;
                ps = int'(p);
                x1 = sdiv(ps, 256);
                x1 = x1 * x1;
                x1 = sdiv(x1 * 3038, 65536);
                x2 = sdiv(-7357 * ps, 65536);
                res.value = ps + sdiv(x1 + x2 + 3791, 16);
            end
        end
        return res;
    endfunction

    // result checker and receiver stall generator
    always @(posedge i_clk) begin
        t_comp_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (compensated_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result kind=%0b value=%0d fault=%0b",
                         $time, o_result_kind, o_value, o_div_fault);
            end else begin
                want = compensated_q.pop_front();
                if (o_result_kind !== want.kind || o_value !== want.value ||
                    o_div_fault !== want.fault) begin
                    error_count++;
                    $display("%0t: mismatch exp %0b/%0d/%0b got %0b/%0d/%0b",
                             $time, want.kind, $signed(want.value), want.fault,
                             o_result_kind, o_value, o_div_fault);
                end
                if (want.kind == KIND_TEMP) temp_seen++;
                else pres_seen++;
                if (want.fault) fault_seen++;
            end
        end
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // drop valid and wait until every transaction has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (compensated_q.size() != 0);
    endtask

    task automatic send_reading(input t_kind kind, input logic [23:0] raw);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_raw_reading <= raw;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        compensated_q.push_back(compensate(kind, raw));
    endtask

    task automatic reg_write(input t_reg idx, input logic [63:0] data);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 8);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COEF_A: cal_a = data;
            REG_COEF_B: cal_b = data;
            REG_COEF_C: cal_c = data[31:0];
            REG_OSS:    cal_oss = data[1:0];
        endcase
        write_count++;
    endtask

    task automatic check_registers();
        logic [63:0] mask, want;
        t_reg idx;
        for (int r = 0; r < 4; r++) begin
            idx = t_reg'(r);
            case (idx)
                REG_COEF_A: begin mask = '1;            want = cal_a; end
                REG_COEF_B: begin mask = '1;            want = cal_b; end
                REG_COEF_C: begin mask = 64'hFFFF_FFFF; want = {32'b0, cal_c}; end
                default:    begin mask = 64'h3;         want = {62'b0, cal_oss}; end
            endcase
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= 5'(idx * 8);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            if ((prdata & mask) !== (want & mask)) begin
                error_count++;
                $display("%0t: register %s readback exp %h got %h",
                         $time, idx.name(), want & mask, prdata & mask);
            end
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    function automatic logic [23:0] pick_raw();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
        return 24'($urandom);
    endfunction

    function automatic logic [63:0] jitter(input logic [63:0] w);
        logic [63:0] r;
        for (int i = 0; i < 4; i++)
            r[16*i +: 16] = w[16*i +: 16] + 16'($urandom_range(64)) - 16'd32;
        return r;
    endfunction

    // all-zero calibration: both kinds hit a zero divisor, pressure with B5 still 0
    task automatic test_reset_values();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        check_registers();
        send_reading(KIND_PRES, 24'h12_3456);
        send_reading(KIND_TEMP, 24'hFF_FFFF);
        settle();
    endtask

    task automatic test_directed();
        reg_write(REG_COEF_A, CAL_A);
        reg_write(REG_COEF_B, CAL_B);
        reg_write(REG_COEF_C, {32'b0, CAL_C});
        reg_write(REG_OSS, 64'd0);
        check_registers();
        // textbook example: UT 27898, UP 23843, oss 0; low byte of temperature ignored
        send_reading(KIND_TEMP, {16'd27898, 8'hA5});
        send_reading(KIND_PRES, {16'd23843, 8'h00});
        send_reading(KIND_TEMP, 24'h0);
        send_reading(KIND_TEMP, 24'hFF_FFFF);
        send_reading(KIND_PRES, 24'h0);
        send_reading(KIND_PRES, 24'hFF_FFFF);
        reg_write(REG_OSS, 64'd3);
        send_reading(KIND_PRES, 24'hFF_FFFF);
        send_reading(KIND_PRES, 24'h0);
        send_reading(KIND_PRES, 24'h5D_2380);
        reg_write(REG_OSS, 64'd1);
        send_reading(KIND_PRES, 24'hA5_5A5A);
        reg_write(REG_OSS, 64'd2);
        send_reading(KIND_PRES, 24'h5A_A5A5);
        // UT equal to AC6 and MD zero: temperature divisor zero, B5 kept for pressure
        reg_write(REG_COEF_C, {32'b0, CAL_C[31:16], 16'h0});
        send_reading(KIND_TEMP, {CAL_B[47:32], 8'h00});
        send_reading(KIND_PRES, 24'h5D_2380);
        // AC4 zero makes B4 zero
        reg_write(REG_COEF_A, {CAL_A[63:16], 16'h0});
        send_reading(KIND_PRES, 24'h5D_2380);
        reg_write(REG_COEF_A, '1);
        reg_write(REG_COEF_B, '1);
        reg_write(REG_COEF_C, {32'b0, 32'hFFFF_FFFF});
        send_reading(KIND_TEMP, 24'hFF_FFFF);
        send_reading(KIND_PRES, 24'hFF_FFFF);
        send_reading(KIND_PRES, 24'h0);
        // most negative signed words (MD at its most positive), largest unsigned ones
        reg_write(REG_COEF_A, 64'h8000_8000_8000_FFFF);
        reg_write(REG_COEF_B, 64'hFFFF_FFFF_8000_8000);
        reg_write(REG_COEF_C, {32'b0, 32'h8000_7FFF});
        send_reading(KIND_TEMP, 24'h0);
        send_reading(KIND_PRES, 24'hFF_FFFF);
        check_registers();
        settle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic [63:0] ca, cb, cc;
        int n, burst;
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
        for (int s = 0; s < 6; s++) begin
            if ($urandom_range(1)) begin
                ca = jitter(CAL_A);
                cb = jitter(CAL_B);
                cc = jitter({32'b0, CAL_C});
            end else begin
                ca = {$urandom, $urandom};
                cb = {$urandom, $urandom};
                cc = {32'b0, $urandom};
            end
            if ($urandom_range(7) == 0)
                ca[15:0] = '0;
            reg_write(REG_COEF_A, ca);
            reg_write(REG_COEF_B, cb);
            reg_write(REG_COEF_C, {32'b0, cc[31:0]});
            reg_write(REG_OSS, (s == 0) ? 64'd0 : (s == 5) ? 64'd3 : 64'($urandom_range(3)));
            n = 0;
            while (n < ITEMS_PER_SETTING) begin
                if ($urandom_range(9) < 7) begin
                    // normal order: a temperature conversion then a few pressure ones
                    send_reading(KIND_TEMP, pick_raw());
                    n++;
                    burst = $urandom_range(1, 4);
                    for (int k = 0; k < burst; k++) begin
                        send_reading(KIND_PRES, pick_raw());
                        n++;
                    end
                end else begin
                    send_reading(t_kind'($urandom_range(1)), pick_raw());
                    n++;
                end
            end
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_random_traffic(23, 65);
        test_random_traffic(65, 23);
        test_random_traffic(0, 0);
        settle();
        repeat (200) @(posedge i_clk);
        $display("checked %0d temperature and %0d pressure transactions, %0d with divide fault",
                 temp_seen, pres_seen, fault_seen);
        $display("%0d calibration writes across oversampling 0..3, %0d failures",
                 write_count, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bsc_pkg.sv
rtl/bsc_div.sv
rtl/baro_sensor_compensation.sv
sim/tb.sv
